[rtl/tlca_pkg.sv]
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared types and action codes of the tree common-ancestor unit.
// ----------------------------------------------------------------------------
package tlca_pkg;

   localparam int NODE_W   = 10;
   localparam int ACTION_W = 2;

   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_LOAD  = 2'd0;
   localparam action_type ACT_BUILD = 2'd1;
   localparam action_type ACT_QUERY = 2'd2;

endpackage

[rtl/tlca_ifs.sv]
// ----------------------------------------------------------------------------
// tlca request and response channels
// Valid/ready channels carrying one request or one response of the unit.
// ----------------------------------------------------------------------------
interface tlca_req_if;
   logic                  valid;
   logic                  ready;
   tlca_pkg::action_type  action;
   tlca_pkg::node_type    node_a;
   tlca_pkg::node_type    node_b;
   tlca_pkg::node_type    node_level;

   modport source (output valid, output action, output node_a, output node_b,
                   output node_level, input ready);
   modport sink   (input valid, input action, input node_a, input node_b,
                   input node_level, output ready);
endinterface

interface tlca_rsp_if;
   logic                  valid;
   logic                  ready;
   tlca_pkg::node_type    ancestor_node;
   tlca_pkg::action_type  done_kind;

   modport source (output valid, output ancestor_node, output done_kind, input ready);
   modport sink   (input valid, input ancestor_node, input done_kind, output ready);
endinterface

[rtl/tree_lca_binary_lifting_unit.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_unit
// Lowest common ancestor of a rooted tree by binary lifting. Parents and
// depths are loaded per node, a build fills the doubling ancestor table,
// a query lifts the deeper node and then descends the levels.
//
//   channel   dir   handshake         contents
//   req_ch    in    valid/ready       action, node_a, node_b, node_level
//   rsp_ch    out   valid/ready       ancestor_node, done_kind
//   csr       in    csr_we            node_count (csr_wdata)
//
// one request at a time; load, unused action and same-node query go straight to done;
// other queries lift the deeper node through each level up to the top set bit of the
// depth difference, then finish if it meets, else descend all levels and read the parent;
// build reads, reads again and writes each node up to node_count at each level above zero
// reset clears control only; depth and ancestor memories hold no reset value
// a result waits in the response register until taken; the next one waits in done
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_unit #(
   parameter int NODES      = 1024,
   parameter int LOG_LEVELS = 10
) (
   input  logic               clock,
   input  logic               reset,
   tlca_req_if.sink           req_ch,
   tlca_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  tlca_pkg::node_type csr_wdata
);

   localparam int NW     = $clog2(NODES);
   localparam int LW     = $clog2(LOG_LEVELS);
   localparam int ADEPTH = LOG_LEVELS << NW;
   localparam int AW     = $clog2(ADEPTH);

   typedef logic [NW-1:0] idx_type;
   typedef logic [LW-1:0] lvl_type;
   typedef logic [AW-1:0] addr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BUILD_RD,
      S_BUILD_MID,
      S_BUILD_WR,
      S_Q_DEPTH,
      S_Q_LIFT,
      S_Q_LIFT_WAIT,
      S_Q_MEET,
      S_Q_DESC_RD,
      S_Q_DESC_CMP,
      S_Q_PARENT_RD,
      S_Q_PARENT,
      S_DONE
   } state_type;

   function automatic logic node_ok(input tlca_pkg::node_type n);
      return (n != '0) && (int'(n) < NODES);
   endfunction

   function automatic addr_type anc_addr(input lvl_type lv, input tlca_pkg::node_type n);
      return addr_type'({lv, idx_type'(n)});
   endfunction

   // memories
   tlca_pkg::node_type anc_mem [0:ADEPTH-1];
   tlca_pkg::node_type dep_mem [0:(1 << NW)-1];

   tlca_pkg::node_type anc_rd0_ff, anc_rd1_ff, dep_rd0_ff, dep_rd1_ff;

   logic               anc_we, dep_we;
   addr_type           anc_waddr, anc_ra0, anc_ra1;
   idx_type            dep_waddr, dep_ra0, dep_ra1;
   tlca_pkg::node_type anc_wdata, dep_wdata;

   // control and datapath registers
   state_type            state_ff;
   tlca_pkg::node_type   node_count_ff;
   tlca_pkg::action_type action_ff;
   tlca_pkg::node_type   a_ff, b_ff, mid_ff, ans_ff, last_ff, j_ff, delta_ff;
   lvl_type              lv_ff;
   logic                 rsp_valid_ff;
   tlca_pkg::node_type   rsp_node_ff;
   tlca_pkg::action_type rsp_kind_ff;

   logic               req_take;
   tlca_pkg::node_type last_in, da, db, pa, pb;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ancestor_node = rsp_node_ff;
   assign rsp_ch.done_kind     = rsp_kind_ff;

   assign last_in = (int'(node_count_ff) > NODES - 1) ? tlca_pkg::node_type'(NODES - 1)
                                                      : node_count_ff;
   assign da = node_ok(a_ff) ? dep_rd0_ff : '0;
   assign db = node_ok(b_ff) ? dep_rd1_ff : '0;
   assign pa = node_ok(a_ff) ? anc_rd0_ff : '0;
   assign pb = node_ok(b_ff) ? anc_rd1_ff : '0;

   // memory access control
   always_comb begin
      anc_we    = 1'b0;
      anc_waddr = '0;
      anc_wdata = '0;
      anc_ra0   = '0;
      anc_ra1   = '0;
      dep_we    = 1'b0;
      dep_waddr = '0;
      dep_wdata = '0;
      dep_ra0   = idx_type'(req_ch.node_a);
      dep_ra1   = idx_type'(req_ch.node_b);
      unique case (state_ff)
         S_IDLE: begin
            if (req_take && req_ch.action == tlca_pkg::ACT_LOAD && node_ok(req_ch.node_a)) begin
               dep_we    = 1'b1;
               dep_waddr = idx_type'(req_ch.node_a);
               dep_wdata = req_ch.node_level;
               anc_we    = 1'b1;
               anc_waddr = anc_addr('0, req_ch.node_a);
               anc_wdata = req_ch.node_b;
            end
         end
         S_BUILD_RD:    anc_ra0 = anc_addr(lv_ff - 1'b1, j_ff);
         S_BUILD_MID:   anc_ra1 = anc_addr(lv_ff - 1'b1, anc_rd0_ff);
         S_BUILD_WR: begin
            anc_we    = 1'b1;
            anc_waddr = anc_addr(lv_ff, j_ff);
            anc_wdata = node_ok(mid_ff) ? anc_rd1_ff : '0;
         end
         S_Q_LIFT:      anc_ra0 = anc_addr(lv_ff, b_ff);
         S_Q_DESC_RD: begin
            anc_ra0 = anc_addr(lv_ff, a_ff);
            anc_ra1 = anc_addr(lv_ff, b_ff);
         end
         S_Q_PARENT_RD: anc_ra0 = anc_addr('0, a_ff);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_waddr] <= anc_wdata;
      end
      anc_rd0_ff <= anc_mem[anc_ra0];
      anc_rd1_ff <= anc_mem[anc_ra1];
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_waddr] <= dep_wdata;
      end
      dep_rd0_ff <= dep_mem[dep_ra0];
      dep_rd1_ff <= dep_mem[dep_ra1];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= tlca_pkg::node_type'(1023);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  action_ff <= req_ch.action;
                  a_ff      <= req_ch.node_a;
                  b_ff      <= req_ch.node_b;
                  ans_ff    <= '0;
                  unique case (req_ch.action)
                     tlca_pkg::ACT_BUILD: begin
                        last_ff  <= last_in;
                        lv_ff    <= lvl_type'(1);
                        j_ff     <= tlca_pkg::node_type'(1);
                        state_ff <= (last_in == '0) ? S_DONE : S_BUILD_RD;
                     end
                     tlca_pkg::ACT_QUERY: begin
                        if (req_ch.node_a == req_ch.node_b) begin
                           ans_ff   <= req_ch.node_a;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_Q_DEPTH;
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_BUILD_RD:  state_ff <= S_BUILD_MID;
            S_BUILD_MID: begin
               mid_ff   <= anc_rd0_ff;
               state_ff <= S_BUILD_WR;
            end
            S_BUILD_WR: begin
               if (j_ff == last_ff) begin
                  if (lv_ff == lvl_type'(LOG_LEVELS - 1)) begin
                     state_ff <= S_DONE;
                  end else begin
                     lv_ff    <= lv_ff + 1'b1;
                     j_ff     <= tlca_pkg::node_type'(1);
                     state_ff <= S_BUILD_RD;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_BUILD_RD;
               end
            end
            S_Q_DEPTH: begin
               // keep the shallower node in a
               if (da > db) begin
                  a_ff     <= b_ff;
                  b_ff     <= a_ff;
                  delta_ff <= da - db;
               end else begin
                  delta_ff <= db - da;
               end
               lv_ff    <= '0;
               state_ff <= S_Q_LIFT;
            end
            S_Q_LIFT, S_Q_LIFT_WAIT: begin
               if (state_ff == S_Q_LIFT && delta_ff[0] && node_ok(b_ff)) begin
                  state_ff <= S_Q_LIFT_WAIT;
               end else begin
                  if (state_ff == S_Q_LIFT_WAIT) begin
                     b_ff <= anc_rd0_ff;
                  end else if (delta_ff[0]) begin
                     b_ff <= '0;
                  end
                  delta_ff <= delta_ff >> 1;
                  if (lv_ff == lvl_type'(LOG_LEVELS - 1) || delta_ff[tlca_pkg::NODE_W-1:1] == '0) begin
                     state_ff <= S_Q_MEET;
                  end else begin
                     lv_ff    <= lv_ff + 1'b1;
                     state_ff <= S_Q_LIFT;
                  end
               end
            end
            S_Q_MEET: begin
               if (a_ff == b_ff) begin
                  ans_ff   <= a_ff;
                  state_ff <= S_DONE;
               end else begin
                  lv_ff    <= lvl_type'(LOG_LEVELS - 1);
                  state_ff <= S_Q_DESC_RD;
               end
            end
            S_Q_DESC_RD: state_ff <= S_Q_DESC_CMP;
            S_Q_DESC_CMP: begin
               if (pa != pb) begin
                  a_ff <= pa;
                  b_ff <= pb;
               end
               if (lv_ff == '0) begin
                  state_ff <= S_Q_PARENT_RD;
               end else begin
                  lv_ff    <= lv_ff - 1'b1;
                  state_ff <= S_Q_DESC_RD;
               end
            end
            S_Q_PARENT_RD: state_ff <= S_Q_PARENT;
            S_Q_PARENT: begin
               ans_ff   <= pa;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_node_ff  <= ans_ff;
                  rsp_kind_ff  <= action_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[dv/tb_tree_lca_binary_lifting_unit.sv]
// ----------------------------------------------------------------------------
// tb_tree_lca_binary_lifting_unit
// Drives loads, builds and common-ancestor queries into the unit and checks
// every response against an in-bench binary-lifting predictor. Trees are
// grown with parents below their children so that every table entry a build
// or query touches has been written. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_tree_lca_binary_lifting_unit;

   localparam int NODES      = 1024;
   localparam int LEVELS     = 10;
   localparam int REPORT_MAX = 10;
   localparam int DEEP_TOP   = 200;
   localparam tlca_pkg::action_type ACT_SPARE = 2'd3;

   typedef struct packed {
      tlca_pkg::action_type action;
      tlca_pkg::node_type   node_a;
      tlca_pkg::node_type   node_b;
      tlca_pkg::node_type   node_level;
   } lca_request_type;

   typedef struct packed {
      tlca_pkg::node_type   ancestor;
      tlca_pkg::action_type kind;
   } lca_answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we;
   tlca_pkg::node_type csr_wdata;

   tlca_req_if req_if();
   tlca_rsp_if rsp_if();

   tree_lca_binary_lifting_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   tlca_pkg::node_type depth_mem [NODES];
   tlca_pkg::node_type jump_tbl [LEVELS][NODES];
   tlca_pkg::node_type node_limit;
   lca_answer_type     pending_answers [$];

   int mismatches  = 0;
   int loaded_upto = 0;
   int built_upto  = 0;
   int n_kind [4]  = '{0, 0, 0, 0};
   bit steady      = 1'b0;
   int rsp_stall   = 0;

   function automatic tlca_pkg::node_type depth_of(tlca_pkg::node_type n);
      return (n == 0) ? '0 : depth_mem[n];
   endfunction

   function automatic tlca_pkg::node_type jump(int lv, tlca_pkg::node_type n);
      return (n == 0) ? '0 : jump_tbl[lv][n];
   endfunction

   function automatic void build_jumps();
      tlca_pkg::node_type mid;
      for (int lv = 1; lv < LEVELS; lv++) begin
         for (int j = 1; j <= int'(node_limit); j++) begin
            mid = jump(lv - 1, tlca_pkg::node_type'(j));
            jump_tbl[lv][j] = (mid == 0) ? '0 : jump(lv - 1, mid);
         end
      end
   endfunction

   function automatic tlca_pkg::node_type common_ancestor(tlca_pkg::node_type a,
                                                          tlca_pkg::node_type b);
      tlca_pkg::node_type x, y, t, dx, dy, delta, px, py;
      if (a == b) return a;
      x  = a;
      y  = b;
      dx = depth_of(x);
      dy = depth_of(y);
      if (dx > dy) begin
         t = x; x = y; y = t;
         t = dx; dx = dy; dy = t;
      end
      delta = dy - dx;
      for (int lv = 0; lv < LEVELS; lv++)
         if (delta[lv]) y = jump(lv, y);
      if (x == y) return x;
      for (int k = LEVELS - 1; k >= 0; k--) begin
         px = jump(k, x);
         py = jump(k, y);
         if (px != py) begin
            x = px;
            y = py;
         end
      end
      return jump(0, x);
   endfunction

   function automatic lca_answer_type apply_request(lca_request_type r);
      lca_answer_type ans;
      ans.kind     = r.action;
      ans.ancestor = '0;
      case (r.action)
         tlca_pkg::ACT_LOAD: begin
            if (r.node_a != 0) begin
               depth_mem[r.node_a]   = r.node_level;
               jump_tbl[0][r.node_a] = r.node_b;
            end
         end
         tlca_pkg::ACT_BUILD: build_jumps();
         tlca_pkg::ACT_QUERY: ans.ancestor = common_ancestor(r.node_a, r.node_b);
         default: ;
      endcase
      return ans;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void report_mismatch(string what, logic [9:0] want, logic [9:0] got);
      if (mismatches < REPORT_MAX)
         $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
   endfunction

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_stall = pick_gap();
         rsp_if.ready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin : check_answers
      lca_answer_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected response, ancestor_node", '0, rsp_if.ancestor_node);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_if.ancestor_node !== want.ancestor)
               report_mismatch("ancestor_node", want.ancestor, rsp_if.ancestor_node);
            if (rsp_if.done_kind !== want.kind)
               report_mismatch("done_kind", 10'(want.kind), 10'(rsp_if.done_kind));
         end
      end
   end

   task automatic send_request(tlca_pkg::action_type act, tlca_pkg::node_type a,
                               tlca_pkg::node_type b, tlca_pkg::node_type lvl);
      int gap;
      lca_request_type r;
      r   = '{act, a, b, lvl};
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.node_a     <= a;
      req_if.node_b     <= b;
      req_if.node_level <= lvl;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_answers = {pending_answers, apply_request(r)};
      n_kind[act]++;
   endtask

   task automatic drain_wait();
      req_if.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(tlca_pkg::node_type v);
      drain_wait();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      node_limit = v;
   endtask

   task automatic issue_build();
      send_request(tlca_pkg::ACT_BUILD, tlca_pkg::node_type'($urandom()),
                   tlca_pkg::node_type'($urandom()), tlca_pkg::node_type'($urandom()));
      if (int'(node_limit) > built_upto) built_upto = int'(node_limit);
   endtask

   // grows the loaded prefix, each parent below its child
   task automatic load_tree_to(int top, int chain_pct);
      tlca_pkg::node_type parent;
      for (int n = loaded_upto + 1; n <= top; n++) begin
         if ($urandom_range(0, 99) < chain_pct) parent = tlca_pkg::node_type'(n - 1);
         else if ($urandom_range(0, 9) == 0) parent = '0;
         else parent = tlca_pkg::node_type'($urandom_range(0, n - 1));
         send_request(tlca_pkg::ACT_LOAD, tlca_pkg::node_type'(n), parent,
                      (parent == 0) ? tlca_pkg::node_type'(0)
                                    : tlca_pkg::node_type'(depth_mem[parent] + 1));
      end
      if (top > loaded_upto) loaded_upto = top;
   endtask

   task automatic send_random_query();
      tlca_pkg::node_type a, b, t;
      int pick;
      b    = tlca_pkg::node_type'($urandom_range(0, built_upto));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         a = b;
         repeat ($urandom_range(1, 12)) if (a != 0) a = jump_tbl[0][a];
      end else if (pick < 45) begin
         a = b;
      end else if (pick < 52) begin
         a = '0;
      end else begin
         a = tlca_pkg::node_type'($urandom_range(0, built_upto));
      end
      if ($urandom_range(0, 1) == 1) begin
         t = a; a = b; b = t;
      end
      send_request(tlca_pkg::ACT_QUERY, a, b, tlca_pkg::node_type'($urandom()));
   endtask

   task automatic random_traffic(int count);
      int pick, n;
      tlca_pkg::node_type parent, lvl;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_random_query();
         end else if (pick < 70) begin
            n      = $urandom_range(1, loaded_upto);
            parent = tlca_pkg::node_type'($urandom_range(0, n - 1));
            if ($urandom_range(0, 3) == 0)
               lvl = tlca_pkg::node_type'($urandom_range(0, NODES - 1));
            else
               lvl = (parent == 0) ? tlca_pkg::node_type'(0)
                                   : tlca_pkg::node_type'(depth_mem[parent] + 1);
            send_request(tlca_pkg::ACT_LOAD, tlca_pkg::node_type'(n), parent, lvl);
         end else if (pick < 78 && loaded_upto < NODES - 1) begin
            send_request(tlca_pkg::ACT_LOAD,
                         tlca_pkg::node_type'($urandom_range(loaded_upto + 1, NODES - 1)),
                         tlca_pkg::node_type'($urandom()), tlca_pkg::node_type'($urandom()));
         end else if (pick < 83) begin
            send_request(tlca_pkg::ACT_LOAD, '0, tlca_pkg::node_type'($urandom()),
                         tlca_pkg::node_type'($urandom()));
         end else if (pick < 90) begin
            send_request(ACT_SPARE, tlca_pkg::node_type'($urandom()),
                         tlca_pkg::node_type'($urandom()), tlca_pkg::node_type'($urandom()));
         end else if (pick < 95) begin
            issue_build();
         end else begin
            drain_wait();
         end
      end
   endtask

   task automatic test_directed_tree();
      write_count(10'd7);
      send_request(tlca_pkg::ACT_LOAD, 10'd1, 10'd0, 10'd0);
      send_request(tlca_pkg::ACT_LOAD, 10'd2, 10'd1, 10'd1);
      send_request(tlca_pkg::ACT_LOAD, 10'd3, 10'd1, 10'd1);
      send_request(tlca_pkg::ACT_LOAD, 10'd4, 10'd2, 10'd2);
      send_request(tlca_pkg::ACT_LOAD, 10'd5, 10'd2, 10'd2);
      send_request(tlca_pkg::ACT_LOAD, 10'd6, 10'd4, 10'd3);
      send_request(tlca_pkg::ACT_LOAD, 10'd7, 10'd3, 10'd2);
      // node zero is ignored, node 1023 lies beyond every build and query
      send_request(tlca_pkg::ACT_LOAD, 10'd0, 10'd5, 10'd1023);
      send_request(tlca_pkg::ACT_LOAD, 10'd1023, 10'd1023, 10'd1023);
      loaded_upto = 7;
      issue_build();
      send_request(tlca_pkg::ACT_QUERY, 10'd6, 10'd5, 10'd0);
      send_request(tlca_pkg::ACT_QUERY, 10'd6, 10'd7, 10'd0);
      send_request(tlca_pkg::ACT_QUERY, 10'd4, 10'd4, 10'd0);
      send_request(tlca_pkg::ACT_QUERY, 10'd0, 10'd6, 10'd0);
      send_request(tlca_pkg::ACT_QUERY, 10'd6, 10'd1, 10'd0);
      send_request(tlca_pkg::ACT_QUERY, 10'd5, 10'd0, 10'd1023);
      send_request(tlca_pkg::ACT_QUERY, 10'd0, 10'd0, 10'd0);
      send_request(ACT_SPARE, 10'd1023, 10'd1023, 10'd1023);
      // reparent without rebuilding, then with an empty build, then rebuilt
      send_request(tlca_pkg::ACT_LOAD, 10'd7, 10'd6, 10'd4);
      send_request(tlca_pkg::ACT_QUERY, 10'd7, 10'd5, 10'd0);
      write_count(10'd0);
      issue_build();
      send_request(tlca_pkg::ACT_QUERY, 10'd7, 10'd5, 10'd0);
      write_count(10'd7);
      issue_build();
      send_request(tlca_pkg::ACT_QUERY, 10'd7, 10'd5, 10'd0);
   endtask

   task automatic test_forest_rounds();
      int top;
      for (int round = 0; round < 5; round++) begin
         top = $urandom_range(8, 80);
         load_tree_to(top, (round % 2 == 0) ? 80 : 20);
         write_count(tlca_pkg::node_type'(top));
         issue_build();
         random_traffic(25);
      end
   endtask

   task automatic test_deep_tree();
      steady = 1'b1;
      load_tree_to(DEEP_TOP, 90);
      steady = 1'b0;
      write_count(tlca_pkg::node_type'(DEEP_TOP));
      issue_build();
      repeat (30) send_random_query();
      write_count(tlca_pkg::node_type'($urandom_range(1, 120)));
      random_traffic(25);
   endtask

   task automatic test_pause_until_drained();
      repeat (8) send_random_query();
      drain_wait();
      steady = 1'b1;
      repeat (8) send_random_query();
      steady = 1'b0;
   endtask

   initial begin
      req_if.valid      <= 1'b0;
      req_if.action     <= tlca_pkg::ACT_LOAD;
      req_if.node_a     <= '0;
      req_if.node_b     <= '0;
      req_if.node_level <= '0;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      node_limit = 10'd1023;
      for (int n = 0; n < NODES; n++) begin
         depth_mem[n] = '0;
         for (int lv = 0; lv < LEVELS; lv++) jump_tbl[lv][n] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_tree();
      test_forest_rounds();
      test_deep_tree();
      test_pause_until_drained();
      drain_wait();
      repeat (40) @(posedge clock);
      $display("covered %0d loads, %0d builds, %0d queries, %0d unused-action requests",
               n_kind[tlca_pkg::ACT_LOAD], n_kind[tlca_pkg::ACT_BUILD],
               n_kind[tlca_pkg::ACT_QUERY], n_kind[ACT_SPARE]);
      $display("ancestor table built over up to %0d nodes, %0d mismatches",
               built_upto, mismatches);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("PASS tree_lca_binary_lifting_unit");
      end else begin
         $display("FAIL tree_lca_binary_lifting_unit");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL tree_lca_binary_lifting_unit");
      $finish;
   end

endmodule
